@@ src/sldf_pkg.sv @@
// Shared types and constants of the sync/length/checksum deframer.
`timescale 1ns / 1ps

package sldf_pkg;

    // Largest accepted frame length (length field counts the checksum too).
    localparam int MAX_FRAME_LEN = 32;

    // Payload buffer depth and widths derived from it.
    localparam int STORE_DEPTH = MAX_FRAME_LEN;
    localparam int CNT_W       = $clog2(MAX_FRAME_LEN);
    localparam int LEN_W       = $clog2(MAX_FRAME_LEN + 1);
    localparam int CMP_W       = CNT_W + 2;

    localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND = 8'h5A;
    localparam logic [15:0] SUM_SEED    = 16'hBEAF;
    localparam logic [15:0] MIN_LEN     = 16'd2;

    typedef enum logic [1:0] {
        STATUS_PAYLOAD  = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_EMPTY    = 2'd2
    } t_status;

    // Parse phase, one-hot.
    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_SYNC2   = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_SUM_LO  = 7'b0010000,
        PH_SUM_HI  = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } t_phase;

    // Handshake control, one-hot.
    typedef enum logic [2:0] {
        ST_IN   = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

endpackage

@@ src/sldf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sync_length_checksum_deframer.sv @@
// Top level: hunts sync, checks length and additive checksum, releases payload words.
// A word that ends a frame gives its first result in the next cycle (error or empty
//   frame), or after a buffer read state (payload).
// Throughput: one input word per cycle between frames; releasing a good frame passes each
//   payload word through a buffer read state, then an output state held until it is taken.
// Input is held off while results of a frame are pending.
// Reset (i_rst_n low, synchronous): hunt for the first sync word, no result pending.
`timescale 1ns / 1ps

module sync_length_checksum_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_payload_byte,
    output logic       o_is_last
);

    localparam int CNT_W = sldf_pkg::CNT_W;
    localparam int LEN_W = sldf_pkg::LEN_W;
    localparam int CMP_W = sldf_pkg::CMP_W;

    // Control state.
    sldf_pkg::t_state  r_state,  n_state;
    sldf_pkg::t_phase  r_phase,  n_phase;
    sldf_pkg::t_status r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    // Frame header and running checksum.
    logic [7:0]        r_len_lo, n_len_lo;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [7:0]        r_recv_lo, n_recv_lo;
    logic [15:0]       r_recv_sum, n_recv_sum;
    logic [15:0]       r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Release walk over the payload buffer.
    logic [CNT_W-1:0]  r_rel_idx, n_rel_idx;
    logic [CNT_W-1:0]  r_rel_cnt, n_rel_cnt;

    // Buffer ports.
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    logic              rx_fire;
    logic              res_fire;
    logic [15:0]       len_full;
    logic [15:0]       recv_full;
    logic [15:0]       sum_add;
    logic [CNT_W-1:0]  cnt_inc;
    logic              payload_done;

    assign rx_fire   = i_rx_valid && o_rx_ready;
    assign res_fire  = o_res_valid && i_res_ready;
    assign len_full  = {i_rx_byte, r_len_lo};
    assign recv_full = {i_rx_byte, r_recv_lo};
    assign sum_add   = r_sum + {8'd0, i_rx_byte};
    assign cnt_inc   = r_cnt + CNT_W'(1);
    // Frame ends once the payload taken plus the two checksum words reaches the length.
    assign payload_done = (CMP_W'(cnt_inc) + CMP_W'(2)) >= CMP_W'(r_len);

    // Store each payload word at its position in the payload.
    assign ram_we = rx_fire && (r_phase == sldf_pkg::PH_PAYLOAD);
    assign ram_re = (r_state == sldf_pkg::ST_READ);

    sldf_ram #(
        .WIDTH (8),
        .DEPTH (sldf_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rel_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_len_lo     = r_len_lo;
        n_len        = r_len;
        n_recv_lo    = r_recv_lo;
        n_recv_sum   = r_recv_sum;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_rel_idx    = r_rel_idx;
        n_rel_cnt    = r_rel_cnt;

        unique case (r_state)
            sldf_pkg::ST_IN: begin
                if (rx_fire) begin
                    unique case (r_phase)
                        sldf_pkg::PH_SYNC2: begin
                            n_phase = (i_rx_byte == sldf_pkg::SYNC_SECOND) ?
                                      sldf_pkg::PH_LEN_LO : sldf_pkg::PH_HUNT;
                        end
                        sldf_pkg::PH_LEN_LO: begin
                            n_len_lo = i_rx_byte;
                            n_phase  = sldf_pkg::PH_LEN_HI;
                        end
                        sldf_pkg::PH_LEN_HI: begin
                            // Drop frames whose length is out of range.
                            n_len = LEN_W'(len_full);
                            if (len_full < sldf_pkg::MIN_LEN ||
                                len_full > 16'(sldf_pkg::MAX_FRAME_LEN)) begin
                                n_phase = sldf_pkg::PH_HUNT;
                            end else begin
                                n_phase = sldf_pkg::PH_SUM_LO;
                            end
                        end
                        sldf_pkg::PH_SUM_LO: begin
                            n_recv_lo = i_rx_byte;
                            n_phase   = sldf_pkg::PH_SUM_HI;
                        end
                        sldf_pkg::PH_SUM_HI: begin
                            n_recv_sum = recv_full;
                            n_sum      = sldf_pkg::SUM_SEED;
                            n_cnt      = '0;
                            if (r_len == LEN_W'(2)) begin
                                // Empty payload: frame ends here.
                                n_phase    = sldf_pkg::PH_HUNT;
                                n_state    = sldf_pkg::ST_OUT;
                                n_out_last = 1'b1;
                                n_out_status = (recv_full == sldf_pkg::SUM_SEED) ?
                                               sldf_pkg::STATUS_EMPTY :
                                               sldf_pkg::STATUS_MISMATCH;
                            end else begin
                                n_phase = sldf_pkg::PH_PAYLOAD;
                            end
                        end
                        sldf_pkg::PH_PAYLOAD: begin
                            n_sum = sum_add;
                            n_cnt = cnt_inc;
                            if (payload_done) begin
                                n_phase = sldf_pkg::PH_HUNT;
                                if (sum_add != r_recv_sum) begin
                                    n_state      = sldf_pkg::ST_OUT;
                                    n_out_status = sldf_pkg::STATUS_MISMATCH;
                                    n_out_last   = 1'b1;
                                end else begin
                                    // Good frame: walk the buffer from the start.
                                    n_state   = sldf_pkg::ST_READ;
                                    n_rel_idx = '0;
                                    n_rel_cnt = cnt_inc;
                                end
                            end
                        end
                        default: begin
                            n_phase = (i_rx_byte == sldf_pkg::SYNC_FIRST) ?
                                      sldf_pkg::PH_SYNC2 : sldf_pkg::PH_HUNT;
                        end
                    endcase
                end
            end
            sldf_pkg::ST_READ: begin
                // Read data lands in the RAM output register next cycle.
                n_state      = sldf_pkg::ST_OUT;
                n_out_status = sldf_pkg::STATUS_PAYLOAD;
                n_out_last   = ((r_rel_idx + CNT_W'(1)) == r_rel_cnt);
            end
            sldf_pkg::ST_OUT: begin
                if (res_fire) begin
                    if (r_out_last) begin
                        n_state = sldf_pkg::ST_IN;
                    end else begin
                        n_state   = sldf_pkg::ST_READ;
                        n_rel_idx = r_rel_idx + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = sldf_pkg::ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sldf_pkg::ST_IN;
            r_phase      <= sldf_pkg::PH_HUNT;
            r_out_status <= sldf_pkg::STATUS_PAYLOAD;
            r_out_last   <= 1'b0;
            r_cnt        <= '0;
            r_sum        <= sldf_pkg::SUM_SEED;
            r_rel_idx    <= '0;
            r_rel_cnt    <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_rel_idx    <= n_rel_idx;
            r_rel_cnt    <= n_rel_cnt;
        end
    end

    // Header fields need no reset: each is written before it is used.
    always_ff @(posedge i_clk) begin
        r_len_lo   <= n_len_lo;
        r_len      <= n_len;
        r_recv_lo  <= n_recv_lo;
        r_recv_sum <= n_recv_sum;
    end

    assign o_rx_ready     = (r_state == sldf_pkg::ST_IN);
    assign o_res_valid    = (r_state == sldf_pkg::ST_OUT);
    assign o_status       = r_out_status;
    assign o_payload_byte = (r_out_status == sldf_pkg::STATUS_PAYLOAD) ? ram_rdata : 8'd0;
    assign o_is_last      = r_out_last;

    // Input and output never both open.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rx_ready && o_res_valid))
        else $error("input ready while a result is pending");

    // Error and empty-frame results are single and so always last.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != sldf_pkg::STATUS_PAYLOAD) |-> o_is_last)
        else $error("non-payload result without last mark");

    // Release walk stays inside the received payload.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sldf_pkg::ST_READ) |-> (r_rel_idx < r_rel_cnt))
        else $error("buffer read beyond payload count");

    // A last result returns the block to input once taken.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && o_is_last) |=> o_rx_ready)
        else $error("block did not reopen input after last result");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the sync/length/checksum deframer.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_WORDS    = 360;
    localparam int DIRECTED_COUNT = 25;

    // Directed words: field extremes, a repeated first sync, an oversize length,
    // a length with a nonzero high byte, then empty frames with good and bad checksums.
    localparam logic [7:0] DIRECTED_WORDS [DIRECTED_COUNT] = '{
        8'h00, 8'hFF, sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND,
        sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND, 8'(sldf_pkg::MAX_FRAME_LEN + 1), 8'h00,
        sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND, 8'h02, 8'h01,
        sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND, sldf_pkg::MIN_LEN[7:0], 8'h00,
        sldf_pkg::SUM_SEED[7:0], sldf_pkg::SUM_SEED[15:8],
        sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND, sldf_pkg::MIN_LEN[7:0], 8'h00,
        8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] value;
        logic       drain_first;
    } t_rx_word;

    typedef struct packed {
        sldf_pkg::t_status status;
        logic [7:0]        payload;
        logic              last;
    } t_result_word;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       rx_valid    = 1'b0;
    logic [7:0] rx_value    = 8'h00;
    logic       res_ready   = 1'b0;
    logic       rx_took     = 1'b0;

    logic       o_rx_ready;
    logic       o_res_valid;
    logic [1:0] o_status;
    logic [7:0] o_payload_byte;
    logic       o_is_last;

    t_rx_word     rx_stream[$];
    t_result_word pending_results[$];
    int           n_errors = 0;

    // Deframer prediction state
    sldf_pkg::t_phase ph;
    logic [15:0] frame_len;
    logic [15:0] sent_sum;
    logic [15:0] payload_sum;
    logic [5:0]  payload_count;
    logic [7:0]  payload_buf [sldf_pkg::MAX_FRAME_LEN];

    // Idle control
    int rx_gap       = 0;
    bit rx_burst     = 1'b0;
    int stall_left   = 0;
    bit res_burst    = 1'b0;
    int idle_cycles  = 0;

    sync_length_checksum_deframer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (rx_value),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (res_ready),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_is_last      (o_is_last)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_word(input logic [7:0] w, input bit drain = 1'b0);
        t_rx_word item;
        item.value       = w;
        item.drain_first = drain;
        rx_stream.push_back(item);
    endtask

    // Frame with plen payload words; corrupt flips at least one checksum bit.
    task automatic add_frame(input int plen, input bit corrupt, input bit drain);
        logic [15:0] len;
        logic [15:0] sum;
        logic [7:0]  body [$];
        logic [7:0]  w;
        len = 16'(plen + 2);
        sum = sldf_pkg::SUM_SEED;
        for (int i = 0; i < plen; i++) begin
            w = 8'($urandom_range(0, 255));
            body.push_back(w);
            sum += 16'(w);
        end
        if (corrupt) begin
            sum ^= 16'($urandom_range(1, 65535));
        end
        push_word(sldf_pkg::SYNC_FIRST, drain);
        push_word(sldf_pkg::SYNC_SECOND);
        push_word(len[7:0]);
        push_word(len[15:8]);
        push_word(sum[7:0]);
        push_word(sum[15:8]);
        foreach (body[i]) begin
            push_word(body[i]);
        end
    endtask

    task automatic add_bad_length(input logic [7:0] lo, input logic [7:0] hi);
        push_word(sldf_pkg::SYNC_FIRST);
        push_word(sldf_pkg::SYNC_SECOND);
        push_word(lo);
        push_word(hi);
    endtask

    task automatic close_frame();
        int count;
        t_result_word res;
        count = int'(frame_len) - 2;
        if (payload_sum != sent_sum) begin
            res = '{sldf_pkg::STATUS_MISMATCH, 8'h00, 1'b1};
            pending_results.push_back(res);
        end else if (count == 0) begin
            res = '{sldf_pkg::STATUS_EMPTY, 8'h00, 1'b1};
            pending_results.push_back(res);
        end else begin
            for (int i = 0; i < count && i < sldf_pkg::MAX_FRAME_LEN; i++) begin
                res = '{sldf_pkg::STATUS_PAYLOAD, payload_buf[i], 1'(i + 1 == count)};
                pending_results.push_back(res);
            end
        end
        ph = sldf_pkg::PH_HUNT;
    endtask

    // Advance the parse by one received word and queue whatever it releases.
    task automatic deframe_word(input logic [7:0] w);
        case (ph)
            sldf_pkg::PH_SYNC2: begin
                ph = (w == sldf_pkg::SYNC_SECOND) ? sldf_pkg::PH_LEN_LO : sldf_pkg::PH_HUNT;
            end
            sldf_pkg::PH_LEN_LO: begin
                frame_len = {8'h00, w};
                ph = sldf_pkg::PH_LEN_HI;
            end
            sldf_pkg::PH_LEN_HI: begin
                frame_len[15:8] = w;
                if (frame_len < sldf_pkg::MIN_LEN || frame_len > sldf_pkg::MAX_FRAME_LEN)
                    ph = sldf_pkg::PH_HUNT;
                else ph = sldf_pkg::PH_SUM_LO;
            end
            sldf_pkg::PH_SUM_LO: begin
                sent_sum = {8'h00, w};
                ph = sldf_pkg::PH_SUM_HI;
            end
            sldf_pkg::PH_SUM_HI: begin
                sent_sum[15:8] = w;
                payload_sum = sldf_pkg::SUM_SEED;
                payload_count = '0;
                if (frame_len == sldf_pkg::MIN_LEN) close_frame();
                else ph = sldf_pkg::PH_PAYLOAD;
            end
            sldf_pkg::PH_PAYLOAD: begin
                if (payload_count < sldf_pkg::MAX_FRAME_LEN)
                    payload_buf[payload_count[4:0]] = w;
                payload_sum = payload_sum + 16'(w);
                payload_count = payload_count + 6'd1;
                if (int'(payload_count) + 2 >= int'(frame_len)) close_frame();
            end
            default: begin
                ph = (w == sldf_pkg::SYNC_FIRST) ? sldf_pkg::PH_SYNC2 : sldf_pkg::PH_HUNT;
            end
        endcase
    endtask

    // Check result words, then predict from the rx word taken at this edge.
    always @(posedge clk) begin
        t_result_word exp_res;
        if (!rst_n) begin
            ph            = sldf_pkg::PH_HUNT;
            frame_len     = '0;
            sent_sum      = '0;
            payload_sum   = sldf_pkg::SUM_SEED;
            payload_count = '0;
            rx_took      <= 1'b0;
        end else begin
            if (o_res_valid && res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d payload_byte %02h is_last %0b",
                           o_status, o_payload_byte, o_is_last);
                    n_errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                        n_errors++;
                    end
                    if (o_payload_byte !== exp_res.payload) begin
                        $error("payload_byte: expected %02h, actual %02h",
                               exp_res.payload, o_payload_byte);
                        n_errors++;
                    end
                    if (o_is_last !== exp_res.last) begin
                        $error("is_last: expected %0b, actual %0b", exp_res.last, o_is_last);
                        n_errors++;
                    end
                end
            end
            rx_took <= rx_valid && o_rx_ready;
            if (rx_valid && o_rx_ready) deframe_word(rx_value);
        end
    end

    // Rx driver: hold the word until taken, then idle or present the next one.
    always @(negedge clk) begin
        t_rx_word item;
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else if (rx_valid && !rx_took) begin
            // hold
        end else if (rx_gap > 0) begin
            rx_valid <= 1'b0;
            rx_gap--;
        end else if (rx_stream.size() != 0 &&
                     !(rx_stream[0].drain_first && pending_results.size() != 0)) begin
            item = rx_stream.pop_front();
            rx_valid <= 1'b1;
            rx_value <= item.value;
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            rx_gap = rx_burst ? 0 : pick_gap();
        end else begin
            rx_valid <= 1'b0;
        end
    end

    // Result side: random stalls with occasional stretches of steady ready.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_ready <= 1'b0;
            stall_left--;
        end else begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 149) == 0) res_burst = !res_burst;
            if (!res_burst && $urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge clk) begin
        if ((rx_valid && o_rx_ready) || (o_res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_length_checksum_deframer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            push_word(DIRECTED_WORDS[i]);
        end
        // One-word and longest payloads first, the first longest one after a full drain.
        add_frame(1, 1'b0, 1'b0);
        add_frame(sldf_pkg::MAX_FRAME_LEN - 2, 1'b0, 1'b1);
        add_bad_length(8'h00, 8'h00);
        add_bad_length(8'h01, 8'h00);
        add_frame(sldf_pkg::MAX_FRAME_LEN - 2, 1'b1, 1'b0);
        while (rx_stream.size() < TOTAL_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_frame(($urandom_range(0, 9) == 0) ? sldf_pkg::MAX_FRAME_LEN - 2
                                                      : $urandom_range(0, 8),
                          1'b0, $urandom_range(0, 24) == 0);
            end else if (r < 80) begin
                add_frame($urandom_range(0, sldf_pkg::MAX_FRAME_LEN - 2), 1'b1, 1'b0);
            end else if (r < 87) begin
                if ($urandom_range(0, 1) == 0)
                    add_bad_length(8'($urandom_range(0, 1)), 8'h00);
                else if ($urandom_range(0, 1) == 0)
                    add_bad_length(8'($urandom_range(sldf_pkg::MAX_FRAME_LEN + 1, 255)),
                                   8'h00);
                else
                    add_bad_length(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
            end else if (r < 93) begin
                push_word(sldf_pkg::SYNC_FIRST);
                push_word(8'($urandom_range(0, 255)) ^ sldf_pkg::SYNC_SECOND ^
                          8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) push_word(8'($urandom_range(0, 255)));
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do begin
            @(negedge clk);
        end while (rx_stream.size() != 0 || rx_valid || pending_results.size() != 0);
        repeat (20) @(posedge clk);

        if (n_errors == 0) begin
            $display("sync_length_checksum_deframer verification clean");
        end else begin
            $display("sync_length_checksum_deframer verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/sldf_pkg.sv
src/sldf_ram.sv
src/sync_length_checksum_deframer.sv
sim/tb.sv
